### rtl/stodc_pkg.sv
// Shared types, constants and digit helpers for the settable time-of-day clock.
package stodc_pkg;

    localparam int KEY_W = 8;
    localparam int TPS_W = 6;
    localparam int HOUR_W = 5;
    localparam int MS_W = 6;

    localparam logic [KEY_W-1:0] KEY_MASK   = 8'h9f;
    localparam logic [KEY_W-1:0] KEY_UP     = 8'h10;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 8'h08;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h04;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h02;
    localparam logic [KEY_W-1:0] KEY_CENTRE = 8'h01;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_KEY  = 1'b1;

    localparam logic [1:0] CUR_HOURS   = 2'd0;
    localparam logic [1:0] CUR_MINUTES = 2'd1;
    localparam logic [1:0] CUR_SECONDS = 2'd2;

    localparam logic [TPS_W-1:0] TPS_RESET = 6'd32;
    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
    localparam logic [MS_W-1:0] MS_MAX = 6'd59;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key_code;
    } t_item;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
        logic       setting_active;
        logic [1:0] cursor_field;
    } t_result;

    // Tens digit of a value below 60, found by a short compare chain.
    function automatic logic [2:0] tens60(input logic [MS_W-1:0] v);
        logic [2:0] t;
        if (v >= 6'd50)      t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones60(input logic [MS_W-1:0] v);
        logic [2:0] t;
        logic [MS_W-1:0] r;
        t = tens60(v);
        r = v - MS_W'({t, 3'b000} + {t, 1'b0});
        return r[3:0];
    endfunction

    function automatic logic [1:0] tens24(input logic [HOUR_W-1:0] h);
        logic [1:0] t;
        if (h >= 5'd20)      t = 2'd2;
        else if (h >= 5'd10) t = 2'd1;
        else                 t = 2'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones24(input logic [HOUR_W-1:0] h);
        logic [1:0] t;
        logic [HOUR_W-1:0] r;
        t = tens24(h);
        r = h - HOUR_W'({t, 3'b000} + {t, 1'b0});
        return r[3:0];
    endfunction

endpackage

### rtl/stodc_in_reg.sv
// Input register stage that holds one accepted word until the update stage takes it.
module stodc_in_reg
    import stodc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_item i_item,
    input  logic  i_out_ready,
    output logic  o_fire,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_fire     = r_valid && i_out_ready;
    assign o_s_tready = !r_valid || i_out_ready;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_valid <= 1'b1;
        end else if (o_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/stodc_update.sv
// Clock state registers with their next-state logic and the digit split of the new time.
module stodc_update
    import stodc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_item            i_item,
    input  logic [TPS_W-1:0] i_tps,
    output t_result          o_result
);

    logic [TPS_W-1:0]  r_pre, n_pre;
    logic [HOUR_W-1:0] r_hour, n_hour;
    logic [MS_W-1:0]   r_min, n_min;
    logic [MS_W-1:0]   r_sec, n_sec;
    logic              r_set, n_set;
    logic [1:0]        r_cur, n_cur;

    logic [KEY_W-1:0] key;
    logic [TPS_W:0]   pre_sum;
    logic             tick, sec_tick, key_on;
    logic             up, down;
    logic             c_s, c_m, c_h, b_s, b_m, b_h;

    assign key     = i_item.key_code & KEY_MASK;
    assign tick    = (i_item.func == FUNC_TICK);
    assign key_on  = (i_item.func == FUNC_KEY) && r_set;
    assign pre_sum = {1'b0, r_pre} + {{TPS_W{1'b0}}, 1'b1};
    assign sec_tick = tick && (pre_sum >= {1'b0, i_tps});
    assign up      = key_on && (key == KEY_UP);
    assign down    = key_on && (key == KEY_DOWN);

    // Carries and borrows ripple from the selected field toward the hours.
    assign c_s = sec_tick || (up && r_cur == CUR_SECONDS);
    assign c_m = (up && r_cur == CUR_MINUTES) || (c_s && r_sec == MS_MAX);
    assign c_h = (up && r_cur == CUR_HOURS) || (c_m && r_min == MS_MAX);
    assign b_s = down && r_cur == CUR_SECONDS;
    assign b_m = (down && r_cur == CUR_MINUTES) || (b_s && r_sec == '0);
    assign b_h = (down && r_cur == CUR_HOURS) || (b_m && r_min == '0);

    always_comb begin
        n_pre = r_pre;
        if (tick) begin
            n_pre = sec_tick ? '0 : pre_sum[TPS_W-1:0];
        end

        n_sec = r_sec;
        if (c_s)      n_sec = (r_sec == MS_MAX) ? '0 : r_sec + 1'b1;
        else if (b_s) n_sec = (r_sec == '0) ? MS_MAX : r_sec - 1'b1;

        n_min = r_min;
        if (c_m)      n_min = (r_min == MS_MAX) ? '0 : r_min + 1'b1;
        else if (b_m) n_min = (r_min == '0) ? MS_MAX : r_min - 1'b1;

        n_hour = r_hour;
        if (c_h)      n_hour = (r_hour == HOUR_MAX) ? '0 : r_hour + 1'b1;
        else if (b_h) n_hour = (r_hour == '0) ? HOUR_MAX : r_hour - 1'b1;

        n_set = r_set;
        n_cur = r_cur;
        if (i_item.func == FUNC_KEY) begin
            if (r_set) begin
                unique case (key)
                    KEY_LEFT: begin
                        if (r_cur != CUR_HOURS) n_cur = r_cur - 1'b1;
                    end
                    KEY_RIGHT: begin
                        if (r_cur != CUR_SECONDS) n_cur = r_cur + 1'b1;
                    end
                    KEY_CENTRE: begin
                        n_set = 1'b0;
                    end
                    default: ;
                endcase
            end else if (key == KEY_CENTRE) begin
                n_set = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre  <= '0;
            r_hour <= '0;
            r_min  <= '0;
            r_sec  <= '0;
            r_set  <= 1'b0;
            r_cur  <= CUR_HOURS;
        end else if (i_fire) begin
            r_pre  <= n_pre;
            r_hour <= n_hour;
            r_min  <= n_min;
            r_sec  <= n_sec;
            r_set  <= n_set;
            r_cur  <= n_cur;
        end
    end

    always_comb begin
        o_result.hour_tens      = tens24(n_hour);
        o_result.hour_ones      = ones24(n_hour);
        o_result.minute_tens    = tens60(n_min);
        o_result.minute_ones    = ones60(n_min);
        o_result.second_tens    = tens60(n_sec);
        o_result.second_ones    = ones60(n_sec);
        o_result.setting_active = n_set;
        o_result.cursor_field   = n_cur;
    end

endmodule

### rtl/settable_time_of_day_clock_core.sv
// Top level of the settable time-of-day clock: ports, tick rate register and output register.
//
// Each input word is a timer tick (tuser low) or a key press (tuser high, key code in
// tdata). A tick advances a prescaler; after ticks_per_second ticks the time moves on by
// one second. The centre key toggles set mode; in set mode left and right move the cursor
// over hours, minutes and seconds, and up and down step the selected field, with carries
// and borrows wrapping around midnight.
// Every input word yields one output word: the six time digits, the set flag and the
// cursor, as they stand after that word is applied.
// The input word sits in the input register, then passes the state update into the output
// register. One word per cycle is sustained while the receiver keeps tready high.
// The tick rate is written on the cfg channel, which is always ready; write it only while
// no word is in flight.
// Reset clears the time to 00:00:00, leaves set mode, puts the cursor on hours and loads a
// tick rate of 32. When the receiver holds tready low the output word is held, the input
// register still takes one word, and then tready on the input side falls.
module settable_time_of_day_clock_core
    import stodc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] key_code
    input  logic [0:0]       i_s_tuser,   // [0] func
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [1:0] hour_tens, [5:2] hour_ones, [8:6] minute_tens, [12:9] minute_ones,
    // [15:13] second_tens, [19:16] second_ones, [20] setting_active,
    // [22:21] cursor_field, [23] zero
    output logic [23:0]      o_m_tdata,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [TPS_W-1:0] i_cfg_data
);

    logic [TPS_W-1:0] r_tps;
    logic             r_out_valid;
    t_result          r_out;

    logic    out_ready;
    logic    fire;
    t_item   in_item;
    t_item   held_item;
    t_result result;

    assign in_item.func     = i_s_tuser[0];
    assign in_item.key_code = i_s_tdata;
    assign out_ready        = !r_out_valid || i_m_tready;
    assign o_cfg_ready      = 1'b1;

    stodc_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_item      (in_item),
        .i_out_ready (out_ready),
        .o_fire      (fire),
        .o_item      (held_item)
    );

    stodc_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .i_tps    (r_tps),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= TPS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tps <= i_cfg_data;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.cursor_field, r_out.setting_active,
                         r_out.second_ones, r_out.second_tens,
                         r_out.minute_ones, r_out.minute_tens,
                         r_out.hour_ones, r_out.hour_tens};

    // The shown time is always a legal time of day.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] != 2'd3) && (o_m_tdata[5:2] <= 4'd9)
                       && !(o_m_tdata[1:0] == 2'd2 && o_m_tdata[5:2] > 4'd3)
                       && (o_m_tdata[8:6] <= 3'd5) && (o_m_tdata[12:9] <= 4'd9)
                       && (o_m_tdata[15:13] <= 3'd5) && (o_m_tdata[19:16] <= 4'd9))
        else $error("time digits out of range");

    // The cursor never leaves the three fields.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[22:21] != 2'd3))
        else $error("cursor out of range");

    // The input side only stalls when the output word is held by the receiver.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // A word taken by the update stage shows up at the output in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_m_tvalid)
        else $error("processed word did not reach the output");

endmodule

### tb/clock_display_checker.sv
// Checker for the time-of-day clock: predicts every display word and compares it on arrival.
module clock_display_checker
    import stodc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] key_code
    input  logic [0:0]       i_s_tuser,   // [0] func
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    // [1:0] hour_tens, [5:2] hour_ones, [8:6] minute_tens, [12:9] minute_ones,
    // [15:13] second_tens, [19:16] second_ones, [20] setting_active,
    // [22:21] cursor_field, [23] zero
    input  logic [23:0]      i_m_tdata,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [TPS_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    localparam int unsigned DAY_SECONDS = 86400;

    // Own copy of the clock state and the tick rate register.
    logic [TPS_W-1:0] tick_rate;
    logic [TPS_W-1:0] prescale;
    logic [16:0]      day_secs;
    logic             set_mode;
    logic [1:0]       cursor;

    t_result expected_display[$];
    t_result got_display;
    t_result want_display;
    int      error_count;

    initial begin
        error_count = 0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [3:0] got,
                                 input logic [3:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
        end
    endtask

    // Applies one word to the predicted state and returns the display it leaves.
    task automatic advance_time_of_day(input logic func, input logic [7:0] key,
                                       output t_result disp);
        logic [TPS_W:0] next_count;
        logic [7:0]     code;
        int unsigned    step;
        int unsigned    hours;
        int unsigned    minutes;
        int unsigned    seconds;
        code = key & KEY_MASK;
        if (func == FUNC_TICK) begin
            // The widened count also catches a prescaler already past a lowered rate.
            next_count = {1'b0, prescale} + 1'b1;
            if (next_count >= {1'b0, tick_rate}) begin
                prescale = '0;
                day_secs = 17'((day_secs + 1) % DAY_SECONDS);
            end else begin
                prescale = next_count[TPS_W-1:0];
            end
        end else if (set_mode) begin
            case (cursor)
                CUR_HOURS:   step = 3600;
                CUR_MINUTES: step = 60;
                default:     step = 1;
            endcase
            case (code)
                KEY_UP:     day_secs = 17'((day_secs + step) % DAY_SECONDS);
                KEY_DOWN:   day_secs = 17'((day_secs + DAY_SECONDS - step) % DAY_SECONDS);
                KEY_LEFT:   if (cursor > CUR_HOURS) cursor = cursor - 1'b1;
                KEY_RIGHT:  if (cursor < CUR_SECONDS) cursor = cursor + 1'b1;
                KEY_CENTRE: set_mode = 1'b0;
                default:    ;
            endcase
        end else if (code == KEY_CENTRE) begin
            set_mode = 1'b1;
        end

        hours = day_secs / 3600;
        minutes = (day_secs / 60) % 60;
        seconds = day_secs % 60;
        disp.hour_tens = 2'(hours / 10);
        disp.hour_ones = 4'(hours % 10);
        disp.minute_tens = 3'(minutes / 10);
        disp.minute_ones = 4'(minutes % 10);
        disp.second_tens = 3'(seconds / 10);
        disp.second_ones = 4'(seconds % 10);
        disp.setting_active = set_mode;
        disp.cursor_field = cursor;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_rate = TPS_RESET;
            prescale = '0;
            day_secs = '0;
            set_mode = 1'b0;
            cursor = CUR_HOURS;
            expected_display.delete();
        end else begin
            // Output first: a word accepted at this edge cannot belong to this edge's input.
            if (i_m_tvalid && i_m_tready) begin
                got_display.hour_tens = i_m_tdata[1:0];
                got_display.hour_ones = i_m_tdata[5:2];
                got_display.minute_tens = i_m_tdata[8:6];
                got_display.minute_ones = i_m_tdata[12:9];
                got_display.second_tens = i_m_tdata[15:13];
                got_display.second_ones = i_m_tdata[19:16];
                got_display.setting_active = i_m_tdata[20];
                got_display.cursor_field = i_m_tdata[22:21];
                if (expected_display.size() == 0) begin
                    report_mismatch("display word arrived with nothing expected");
                end else begin
                    want_display = expected_display.pop_front();
                    compare_field("hour_tens", 4'(got_display.hour_tens),
                                  4'(want_display.hour_tens));
                    compare_field("hour_ones", got_display.hour_ones,
                                  want_display.hour_ones);
                    compare_field("minute_tens", 4'(got_display.minute_tens),
                                  4'(want_display.minute_tens));
                    compare_field("minute_ones", got_display.minute_ones,
                                  want_display.minute_ones);
                    compare_field("second_tens", 4'(got_display.second_tens),
                                  4'(want_display.second_tens));
                    compare_field("second_ones", got_display.second_ones,
                                  want_display.second_ones);
                    compare_field("setting_active", 4'(got_display.setting_active),
                                  4'(want_display.setting_active));
                    compare_field("cursor_field", 4'(got_display.cursor_field),
                                  4'(want_display.cursor_field));
                    compare_field("pad bit", 4'(i_m_tdata[23]), 4'd0);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                tick_rate = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_time_of_day(i_s_tuser[0], i_s_tdata, want_display);
                expected_display.push_back(want_display);
            end
        end
        o_pending <= expected_display.size();
        o_errors <= error_count;
    end

endmodule

### tb/tb_top.sv
// Testbench top for the time-of-day clock: clock, reset, stimulus, idling and the verdict.
module tb_top
    import stodc_pkg::*;
();

    localparam int ITEMS_PER_PHASE = 190;
    localparam int RANDOM_PHASES = 10;
    localparam int MAX_GAP = 18;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic [0:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TPS_W-1:0] cfg_data = '0;
    int               errors;
    int               pending;
    logic             no_idle = 1'b0;

    settable_time_of_day_clock_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    clock_display_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Valid stays high after a word is taken, so back-to-back words never drop it.
    task automatic send_word(input logic func, input logic [7:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= key;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_display();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_tick_rate(input logic [TPS_W-1:0] rate);
        drain_display();
        cfg_valid <= 1'b1;
        cfg_data <= rate;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ticks and short key codes with the masked-off bits set at random; the rest noise.
    task automatic send_random_word();
        int         pick;
        logic [7:0] noise;
        logic [7:0] key;
        pick = $urandom_range(0, 99);
        noise = 8'($urandom);
        if (pick < 45) begin
            send_word(FUNC_TICK, noise);
        end else if (pick < 88) begin
            case ($urandom_range(0, 9))
                0, 1:    key = KEY_UP;
                2, 3:    key = KEY_DOWN;
                4, 5:    key = KEY_LEFT;
                6, 7:    key = KEY_RIGHT;
                default: key = KEY_CENTRE;
            endcase
            send_word(FUNC_KEY, key | (noise & 8'h60));
        end else begin
            send_word(FUNC_KEY, noise);
        end
    endtask

    initial begin : display_sink
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int               phase;
        int               n;
        logic [TPS_W-1:0] rate;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With a rate of zero every tick moves the time on.
        set_tick_rate(6'd0);
        send_word(FUNC_TICK, 8'h00);
        send_word(FUNC_TICK, KEY_CENTRE);
        send_word(FUNC_KEY, KEY_UP);
        send_word(FUNC_KEY, 8'hff);
        send_word(FUNC_KEY, KEY_CENTRE);
        send_word(FUNC_KEY, KEY_RIGHT);
        send_word(FUNC_KEY, KEY_RIGHT);
        send_word(FUNC_KEY, KEY_RIGHT);
        send_word(FUNC_KEY, KEY_DOWN);
        send_word(FUNC_KEY, KEY_UP);
        send_word(FUNC_KEY, KEY_LEFT);
        send_word(FUNC_KEY, KEY_LEFT);
        send_word(FUNC_KEY, KEY_LEFT);
        send_word(FUNC_KEY, KEY_DOWN);
        send_word(FUNC_KEY, KEY_UP);
        send_word(FUNC_KEY, KEY_RIGHT);
        send_word(FUNC_KEY, KEY_DOWN);
        send_word(FUNC_KEY, KEY_UP);
        send_word(FUNC_KEY, 8'h81);
        // Upper bits fall to the mask, leaving a centre press that ends set mode.
        send_word(FUNC_KEY, 8'h61);

        // The prescaler holds four when the rate drops to two; the next tick must carry.
        set_tick_rate(6'd63);
        repeat (4) send_word(FUNC_TICK, 8'h00);
        set_tick_rate(6'd2);
        send_word(FUNC_TICK, 8'h00);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       rate = 6'd1;
                1:       rate = 6'd63;
                2:       rate = 6'd0;
                default: rate = 6'($urandom_range(1, 63));
            endcase
            no_idle = (phase % 4 == 1);
            set_tick_rate(rate);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 5 && n == ITEMS_PER_PHASE / 2) begin
                    drain_display();
                end
                send_random_word();
            end
        end

        drain_display();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
